>>> sv/sbcc_pkg.sv
package sbcc_pkg;

    // screen and sprite limits
    localparam int SCREEN_WIDTH   = 640;
    localparam int SCREEN_HEIGHT  = 480;
    localparam int MAX_SPRITE_DIM = 1024;
    localparam int PERCENT_FULL   = 100;

    // field widths
    localparam int COORD_W = 10;
    localparam int DIM_W   = 11;
    localparam int ORG_W   = 12;
    localparam int PCT_W   = 7;
    localparam int PITCH_W = 16;
    localparam int KEY_W   = 24;
    localparam int SX_W    = 10;
    localparam int SY_W    = 9;
    localparam int ADDR_W  = 25;
    localparam int PIX_W   = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_KEY     = 4'd0,
        REG_DRAW_MODE     = 4'd1,
        REG_SPRITE_WIDTH  = 4'd2,
        REG_SPRITE_HEIGHT = 4'd3,
        REG_ORIGIN_X      = 4'd4,
        REG_ORIGIN_Y      = 4'd5,
        REG_WIDTH_PERCENT = 4'd6,
        REG_DEST_PITCH    = 4'd7
    } cfg_index_t;

    // drawing modes
    typedef enum logic [1:0] {
        MODE_COPY  = 2'd0,
        MODE_KEYED = 2'd1,
        MODE_BLEND = 2'd2,
        MODE_TINT  = 2'd3
    } draw_mode_t;

    typedef struct packed {
        logic [KEY_W-1:0]   color_key;
        draw_mode_t         draw_mode;
        logic [DIM_W-1:0]   sprite_width;
        logic [DIM_W-1:0]   sprite_height;
        logic [ORG_W-1:0]   origin_x;
        logic [ORG_W-1:0]   origin_y;
        logic [PCT_W-1:0]   width_percent;
        logic [PITCH_W-1:0] dest_pitch;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pos_t;

    typedef struct packed {
        logic [PIX_W-1:0] src_pixel;
        logic [PIX_W-1:0] dst_pixel;
    } in_word_t;

    typedef struct packed {
        logic              write_enable;
        logic [PIX_W-1:0]  pixel_out;
        logic [SX_W-1:0]   screen_x;
        logic [SY_W-1:0]   screen_y;
        logic [ADDR_W-1:0] dest_address;
        logic              last_pixel;
    } out_word_t;

    // zero counts as one, oversize saturates
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_SPRITE_DIM))
        begin
            r = DIM_W'(MAX_SPRITE_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> sv/sbcc_cfg.sv
module sbcc_cfg
    import sbcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic                  restart
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic hit;

    // decode register write
    always_comb
    begin
        cfg_next = cfg_reg;
        hit      = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COLOR_KEY:
                begin
                    cfg_next.color_key = cfg_data[KEY_W-1:0];
                    hit = 1'b1;
                end
                REG_DRAW_MODE:
                begin
                    cfg_next.draw_mode = draw_mode_t'(cfg_data[1:0]);
                    hit = 1'b1;
                end
                REG_SPRITE_WIDTH:
                begin
                    cfg_next.sprite_width = cfg_data[DIM_W-1:0];
                    hit = 1'b1;
                end
                REG_SPRITE_HEIGHT:
                begin
                    cfg_next.sprite_height = cfg_data[DIM_W-1:0];
                    hit = 1'b1;
                end
                REG_ORIGIN_X:
                begin
                    cfg_next.origin_x = cfg_data[ORG_W-1:0];
                    hit = 1'b1;
                end
                REG_ORIGIN_Y:
                begin
                    cfg_next.origin_y = cfg_data[ORG_W-1:0];
                    hit = 1'b1;
                end
                REG_WIDTH_PERCENT:
                begin
                    cfg_next.width_percent = cfg_data[PCT_W-1:0];
                    hit = 1'b1;
                end
                REG_DEST_PITCH:
                begin
                    cfg_next.dest_pitch = cfg_data[PITCH_W-1:0];
                    hit = 1'b1;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_key     <= '0;
            cfg_reg.draw_mode     <= MODE_COPY;
            cfg_reg.sprite_width  <= DIM_W'(1);
            cfg_reg.sprite_height <= DIM_W'(1);
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.width_percent <= PCT_W'(PERCENT_FULL);
            cfg_reg.dest_pitch    <= PITCH_W'(2560);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg     = cfg_reg;
    assign restart = hit;

endmodule

>>> sv/sbcc_pos.sv
module sbcc_pos
    import sbcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic restart,
    input  logic advance,
    output pos_t pos
);

    pos_t             pos_reg;
    pos_t             pos_next;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             col_end;
    logic             row_end;

    // raster order walk with wrap at sprite end
    always_comb
    begin
        w        = clamp_dim(cfg.sprite_width);
        h        = clamp_dim(cfg.sprite_height);
        col_end  = ({1'b0, pos_reg.col} + DIM_W'(1)) >= w;
        row_end  = ({1'b0, pos_reg.row} + DIM_W'(1)) >= h;
        pos_next = pos_reg;
        if (restart)
        begin
            pos_next = '0;
        end
        else if (advance)
        begin
            if (col_end)
            begin
                pos_next.col = '0;
                pos_next.row = row_end ? '0 : pos_reg.row + COORD_W'(1);
            end
            else
            begin
                pos_next.col = pos_reg.col + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

>>> sv/sbcc_pix.sv
module sbcc_pix
    import sbcc_pkg::*;
(
    input  cfg_t      cfg,
    input  pos_t      pos,
    input  in_word_t  word,
    output out_word_t result
);

    localparam int PROD_W = DIM_W + PCT_W;
    localparam int X_W    = ORG_W + 1;

    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [PCT_W-1:0]   pct;
    logic [PROD_W-1:0]  width_prod;
    logic [PROD_W-1:0]  col_scaled;
    logic [X_W-1:0]     x;
    logic [X_W-1:0]     y;
    logic               on_screen;
    logic               we;
    logic [PIX_W-1:0]   pix;
    logic [PIX_W-1:0]   blend;
    logic [ADDR_W-1:0]  row_offset;
    logic [SX_W-1:0]    ux;
    logic [SY_W-1:0]    uy;

    // target position and screen clip
    always_comb
    begin
        x  = {cfg.origin_x[ORG_W-1], cfg.origin_x} + {{(X_W-COORD_W){1'b0}}, pos.col};
        y  = {cfg.origin_y[ORG_W-1], cfg.origin_y} + {{(X_W-COORD_W){1'b0}}, pos.row};
        on_screen = !x[X_W-1] && (x < X_W'(SCREEN_WIDTH))
                 && !y[X_W-1] && (y < X_W'(SCREEN_HEIGHT));
        ux = x[SX_W-1:0];
        uy = y[SY_W-1:0];
    end

    // width limit: col >= floor(w*pct/100) iff w*pct <= 100*col + 99
    always_comb
    begin
        w          = clamp_dim(cfg.sprite_width);
        h          = clamp_dim(cfg.sprite_height);
        pct        = (cfg.width_percent > PCT_W'(PERCENT_FULL))
                   ? PCT_W'(PERCENT_FULL) : cfg.width_percent;
        width_prod = PROD_W'(w) * PROD_W'(pct);
        col_scaled = PROD_W'(pos.col) * PROD_W'(PERCENT_FULL)
                   + PROD_W'(PERCENT_FULL - 1);
        we = on_screen;
        if (cfg.draw_mode != MODE_COPY)
        begin
            if (width_prod <= col_scaled)
            begin
                we = 1'b0;
            end
            if (word.src_pixel[KEY_W-1:0] == cfg.color_key)
            begin
                we = 1'b0;
            end
        end
    end

    // pixel colour by mode
    always_comb
    begin
        blend = '0;
        for (int i = 0; i < 3; i++)
        begin
            blend[8*i +: 8] = {1'b0, word.src_pixel[8*i+1 +: 7]}
                            + {1'b0, word.dst_pixel[8*i+1 +: 7]};
        end
        unique case (cfg.draw_mode)
            MODE_BLEND:
            begin
                pix = blend;
            end
            MODE_TINT:
            begin
                pix = {word.src_pixel[31:16],
                       1'b0, word.src_pixel[15:9],
                       1'b0, word.src_pixel[7:1]};
            end
            default:
            begin
                pix = word.src_pixel;
            end
        endcase
    end

    // frame buffer address
    assign row_offset = ADDR_W'(uy) * ADDR_W'(cfg.dest_pitch);

    // result word, all fields but last_pixel zeroed when not written
    always_comb
    begin
        result = '0;
        result.last_pixel = (({1'b0, pos.col} + DIM_W'(1)) >= w)
                         && (({1'b0, pos.row} + DIM_W'(1)) >= h);
        if (we)
        begin
            result.write_enable = 1'b1;
            result.pixel_out    = pix;
            result.screen_x     = ux;
            result.screen_y     = uy;
            result.dest_address = row_offset + ADDR_W'({ux, 2'b00});
        end
    end

endmodule

>>> sv/sprite_blit_colorkey_clip_top.sv
// sprite blitter with colour key and per-pixel clipping
// the input stage registers each accepted word, the result stage registers its result word
// throughput: one word per cycle; the input stalls only while both stages
// hold words and the output is stalled
// reset: rst_n asynchronous active low; registers return to defaults,
// position returns to column 0 row 0, both pipeline stages empty
module sprite_blit_colorkey_clip_top
    import sbcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_data
);

    cfg_t      cfg;
    logic      restart;
    pos_t      pos;
    logic      in_take;
    logic      out_move;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_word_t  s1_word_reg;
    pos_t      s1_pos_reg;
    out_word_t result;
    logic      s2_valid_reg;
    logic      s2_valid_next;
    out_word_t s2_word_reg;

    sbcc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .restart   (restart)
    );

    sbcc_pos u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (restart),
        .advance (in_take),
        .pos     (pos)
    );

    sbcc_pix u_pix (
        .cfg    (cfg),
        .pos    (s1_pos_reg),
        .word   (s1_word_reg),
        .result (result)
    );

    // pipeline flow control
    always_comb
    begin
        out_move      = !s2_valid_reg || !out_stall;
        in_stall      = s1_valid_reg && !out_move;
        in_take       = in_valid && !in_stall;
        s1_valid_next = in_take || (s1_valid_reg && !out_move);
        s2_valid_next = out_move ? s1_valid_reg : s2_valid_reg;
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // input stage holds the word and its sprite position
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_word_reg <= in_data;
            s1_pos_reg  <= pos;
        end
    end

    // result stage
    always_ff @(posedge clk)
    begin
        if (out_move && s1_valid_reg)
        begin
            s2_word_reg <= result;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_word_reg;

endmodule

>>> sv/sbcc_checker.sv
module sbcc_checker
    import sbcc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input out_word_t             out_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // input side backs up only when the output is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // unwritten pixel carries zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.write_enable |->
            out_data.pixel_out == '0 && out_data.screen_x == '0
            && out_data.screen_y == '0 && out_data.dest_address == '0)
        else $error("non-zero fields on unwritten pixel");

    // written pixel lies on screen
    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.write_enable |->
            out_data.screen_x < SX_W'(SCREEN_WIDTH)
            && out_data.screen_y < SY_W'(SCREEN_HEIGHT))
        else $error("written pixel off screen");

endmodule

bind sprite_blit_colorkey_clip_top sbcc_checker u_sbcc_checker (.*);

>>> tb/sv/sprite_blit_colorkey_clip_top_tb.sv
`timescale 1ns / 100ps

module sprite_blit_colorkey_clip_top_tb;

    import sbcc_pkg::*;

    // indexes past the end of the register list, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX_HI = 4'd15;
    localparam int IDLE_PCT = 38;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_data;

    // own copy of the register file and sprite position
    logic [KEY_W-1:0]        key_reg;
    draw_mode_t              mode_reg;
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic signed [ORG_W-1:0] org_x;
    logic signed [ORG_W-1:0] org_y;
    logic [PCT_W-1:0]        pct_reg;
    logic [PITCH_W-1:0]      pitch_reg;
    int                      col_pos;
    int                      row_pos;

    out_word_t predicted_words[$];
    int        mismatch_count;
    bit        calm_tx;
    bit        calm_rx;
    int        hold_left;

    sprite_blit_colorkey_clip_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // effective sprite dimension: zero counts as one, oversize saturates
    function automatic int dim_eff(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > MAX_SPRITE_DIM)
        begin
            return MAX_SPRITE_DIM;
        end
        return int'(v);
    endfunction

    // expected result word for one pixel, advances the sprite position
    function automatic out_word_t predict_pixel(input in_word_t px);
        int          w;
        int          h;
        int          x;
        int          y;
        int          pct;
        int          lim;
        int          i;
        logic        we;
        logic [31:0] pix;
        logic [31:0] addr;
        out_word_t   r;
        w = dim_eff(width_reg);
        h = dim_eff(height_reg);
        x = org_x + col_pos;
        y = org_y + row_pos;
        we = (x >= 0) && (x < SCREEN_WIDTH) && (y >= 0) && (y < SCREEN_HEIGHT);
        // width limit and colour key only apply outside plain copy
        if (mode_reg != MODE_COPY)
        begin
            pct = (int'(pct_reg) > PERCENT_FULL) ? PERCENT_FULL : int'(pct_reg);
            lim = (w * pct) / PERCENT_FULL;
            if (col_pos >= lim)
            begin
                we = 1'b0;
            end
            if (px.src_pixel[KEY_W-1:0] == key_reg)
            begin
                we = 1'b0;
            end
        end
        case (mode_reg)
            MODE_BLEND:
            begin
                pix = '0;
                for (i = 0; i < 3; i++)
                begin
                    pix[8*i +: 8] = (px.src_pixel[8*i +: 8] >> 1)
                                  + (px.dst_pixel[8*i +: 8] >> 1);
                end
            end
            MODE_TINT:
            begin
                pix = {px.src_pixel[31:16], px.src_pixel[15:8] >> 1,
                       px.src_pixel[7:0] >> 1};
            end
            default:
            begin
                pix = px.src_pixel;
            end
        endcase
        r = '0;
        if (we)
        begin
            addr = y * pitch_reg + x * 4;
            r.write_enable = 1'b1;
            r.pixel_out    = pix;
            r.screen_x     = x[SX_W-1:0];
            r.screen_y     = y[SY_W-1:0];
            r.dest_address = addr[ADDR_W-1:0];
        end
        r.last_pixel = (col_pos + 1 >= w) && (row_pos + 1 >= h);
        // raster walk with wrap at the end of the sprite
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
        return r;
    endfunction

    function automatic in_word_t rand_pixel();
        in_word_t px;
        px.src_pixel = $urandom;
        px.dst_pixel = $urandom;
        if ($urandom_range(3) == 0)
        begin
            px.src_pixel[KEY_W-1:0] = key_reg;
        end
        return px;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(9))
            0: return '0;
            1: return 24'($urandom_range(0, 2047));
            2: return 24'd2047;
            default: return 24'($urandom_range(1, 6));
        endcase
    endfunction

    // origins cluster around the screen edges, with the register extremes
    function automatic logic [CFG_DATA_W-1:0] pick_origin(input int span);
        logic [ORG_W-1:0] v;
        case ($urandom_range(5))
            0: v = ORG_W'(-int'($urandom_range(0, 8)));
            1: v = ORG_W'(span - int'($urandom_range(0, 8)));
            2: v = ORG_W'($urandom_range(0, span));
            3: v = ORG_W'($urandom);
            4: v = 12'h800;
            default: v = 12'h7ff;
        endcase
        return {12'b0, v};
    endfunction

    // drop the input valid and wait until every expected word has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        bit known;
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        known = 1'b1;
        case (idx)
            REG_COLOR_KEY:     key_reg    = val[KEY_W-1:0];
            REG_DRAW_MODE:     mode_reg   = draw_mode_t'(val[1:0]);
            REG_SPRITE_WIDTH:  width_reg  = val[DIM_W-1:0];
            REG_SPRITE_HEIGHT: height_reg = val[DIM_W-1:0];
            REG_ORIGIN_X:      org_x      = val[ORG_W-1:0];
            REG_ORIGIN_Y:      org_y      = val[ORG_W-1:0];
            REG_WIDTH_PERCENT: pct_reg    = val[PCT_W-1:0];
            REG_DEST_PITCH:    pitch_reg  = val[PITCH_W-1:0];
            default:           known      = 1'b0;
        endcase
        // any real register write restarts the sprite
        if (known)
        begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    // offer one word with random gaps, predict on acceptance
    task automatic send_pixel(input in_word_t px);
        while (!calm_tx && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (in_stall);
        predicted_words.push_back(predict_pixel(px));
    endtask

    task automatic compare_field(input string fname, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("%0t: %s expected %h got %h", $realtime, fname, exp_v, got_v);
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t: result word with nothing expected: %h",
                             $realtime, out_data);
                end
            end
            else
            begin
                exp_w = predicted_words.pop_front();
                compare_field("write_enable", exp_w.write_enable, out_data.write_enable);
                compare_field("pixel_out", exp_w.pixel_out, out_data.pixel_out);
                compare_field("screen_x", exp_w.screen_x, out_data.screen_x);
                compare_field("screen_y", exp_w.screen_y, out_data.screen_y);
                compare_field("dest_address", exp_w.dest_address, out_data.dest_address);
                compare_field("last_pixel", exp_w.last_pixel, out_data.last_pixel);
            end
        end
    end

    // receiver: random stalls, calm stretches and a counted hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (calm_rx)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic test_after_reset();
        send_pixel(in_word_t'{32'h0000_0000, 32'h0000_0000});
        send_pixel(in_word_t'{32'hffff_ffff, 32'hffff_ffff});
    endtask

    task automatic test_draw_modes();
        draw_mode_t all_modes[4];
        all_modes = '{MODE_COPY, MODE_KEYED, MODE_BLEND, MODE_TINT};
        write_reg(REG_SPRITE_WIDTH, 24'd4);
        write_reg(REG_SPRITE_HEIGHT, 24'd2);
        write_reg(REG_ORIGIN_X, 24'd10);
        write_reg(REG_ORIGIN_Y, 24'd20);
        write_reg(REG_COLOR_KEY, 24'hffffff);
        foreach (all_modes[i])
        begin
            write_reg(REG_DRAW_MODE, 24'(all_modes[i]));
            // key match, then an ordinary pixel
            send_pixel(in_word_t'{32'h00ff_ffff, 32'hffff_ffff});
            send_pixel(in_word_t'{32'h80fe_0181, 32'h7f03_ff02});
        end
        // half width: third column falls outside the drawn part
        write_reg(REG_WIDTH_PERCENT, 24'd50);
        send_pixel(in_word_t'{32'h1234_5678, 32'h0});
        send_pixel(in_word_t'{32'h9abc_def0, 32'h0});
        send_pixel(in_word_t'{32'h0f0f_0f0f, 32'h0});
        write_reg(REG_WIDTH_PERCENT, 24'd100);
    endtask

    task automatic test_screen_edges();
        int i;
        write_reg(REG_DRAW_MODE, 24'(MODE_COPY));
        write_reg(REG_SPRITE_WIDTH, 24'd2);
        write_reg(REG_SPRITE_HEIGHT, 24'd2);
        write_reg(REG_DEST_PITCH, 24'd65535);
        write_reg(REG_ORIGIN_X, {12'b0, 12'hfff});
        write_reg(REG_ORIGIN_Y, 24'd479);
        for (i = 0; i < 4; i++)
            send_pixel(rand_pixel());
        write_reg(REG_DEST_PITCH, 24'd0);
        write_reg(REG_ORIGIN_X, 24'd639);
        write_reg(REG_ORIGIN_Y, {12'b0, 12'hfff});
        for (i = 0; i < 4; i++)
            send_pixel(rand_pixel());
        write_reg(REG_DEST_PITCH, 24'd2560);
    endtask

    task automatic test_odd_sizes();
        write_reg(REG_ORIGIN_X, 24'd0);
        write_reg(REG_ORIGIN_Y, 24'd0);
        write_reg(REG_SPRITE_WIDTH, 24'd0);
        write_reg(REG_SPRITE_HEIGHT, 24'd0);
        send_pixel(rand_pixel());
        write_reg(REG_SPRITE_WIDTH, 24'd3);
        write_reg(REG_SPRITE_HEIGHT, 24'd1);
        send_pixel(rand_pixel());
        // ignored index keeps the position, a real write restarts it
        write_reg(UNUSED_INDEX_LO, 24'hffffff);
        send_pixel(rand_pixel());
        write_reg(REG_ORIGIN_Y, {12'b0, 12'h800});
        write_reg(REG_ORIGIN_X, {12'b0, 12'h7ff});
        send_pixel(rand_pixel());
        write_reg(UNUSED_INDEX_HI, 24'h000000);
        send_pixel(rand_pixel());
        send_pixel(rand_pixel());
    endtask

    // oversize width with a narrow drawn part, clipped at the left edge
    task automatic test_widest_row();
        int i;
        write_reg(REG_DRAW_MODE, 24'(MODE_KEYED));
        write_reg(REG_COLOR_KEY, 24'($urandom));
        write_reg(REG_WIDTH_PERCENT, 24'd1);
        write_reg(REG_SPRITE_WIDTH, 24'd2047);
        write_reg(REG_SPRITE_HEIGHT, 24'd1);
        write_reg(REG_ORIGIN_X, {12'b0, ORG_W'(-4)});
        write_reg(REG_ORIGIN_Y, 24'd479);
        for (i = 0; i < 24; i++)
            send_pixel(rand_pixel());
    endtask

    task automatic test_streaming();
        int i;
        calm_tx = 1'b1;
        calm_rx = 1'b1;
        write_reg(REG_DRAW_MODE, 24'(MODE_BLEND));
        write_reg(REG_WIDTH_PERCENT, 24'd100);
        write_reg(REG_SPRITE_WIDTH, 24'd5);
        write_reg(REG_SPRITE_HEIGHT, 24'd3);
        write_reg(REG_ORIGIN_X, 24'd300);
        write_reg(REG_ORIGIN_Y, 24'd200);
        for (i = 0; i < 45; i++)
            send_pixel(rand_pixel());
        wait_idle();
        calm_rx = 1'b0;
        calm_tx = 1'b0;
    endtask

    // receiver holds off while words keep coming, so the input backs up
    task automatic test_backpressure();
        int i;
        write_reg(REG_DRAW_MODE, 24'(MODE_TINT));
        write_reg(REG_SPRITE_WIDTH, 24'd6);
        write_reg(REG_SPRITE_HEIGHT, 24'd4);
        calm_tx = 1'b1;
        hold_left = 80;
        for (i = 0; i < 30; i++)
            send_pixel(rand_pixel());
        calm_tx = 1'b0;
    endtask

    task automatic test_random_sprites();
        int                    sent;
        int                    n;
        int                    count;
        logic [CFG_DATA_W-1:0] key;
        sent = 0;
        while (sent < 280)
        begin
            case ($urandom_range(3))
                0: key = '0;
                1: key = 24'hffffff;
                default: key = 24'($urandom);
            endcase
            write_reg(REG_COLOR_KEY, key);
            write_reg(REG_DRAW_MODE, 24'($urandom_range(3)));
            write_reg(REG_SPRITE_WIDTH, pick_dim());
            write_reg(REG_SPRITE_HEIGHT, pick_dim());
            write_reg(REG_ORIGIN_X, pick_origin(SCREEN_WIDTH));
            write_reg(REG_ORIGIN_Y, pick_origin(SCREEN_HEIGHT));
            write_reg(REG_WIDTH_PERCENT, 24'($urandom_range(0, 127)));
            write_reg(REG_DEST_PITCH, ($urandom_range(1) == 0)
                      ? 24'd2560 : 24'($urandom_range(0, 65535)));
            if ($urandom_range(3) == 0)
            begin
                write_reg(CFG_IDX_W'($urandom_range(UNUSED_INDEX_LO, UNUSED_INDEX_HI)),
                          24'($urandom));
            end
            // a random count of up to a whole sprite plus two words where it is small, else up to 40 words
            n = dim_eff(width_reg) * dim_eff(height_reg) + 2;
            count = $urandom_range(1, (n < 40) ? n : 40);
            repeat (count) send_pixel(rand_pixel());
            sent += count;
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        calm_tx    = 1'b0;
        calm_rx    = 1'b0;
        hold_left  = 0;
        mismatch_count = 0;
        key_reg    = '0;
        mode_reg   = MODE_COPY;
        width_reg  = DIM_W'(1);
        height_reg = DIM_W'(1);
        org_x      = '0;
        org_y      = '0;
        pct_reg    = PCT_W'(PERCENT_FULL);
        pitch_reg  = PITCH_W'(2560);
        col_pos    = 0;
        row_pos    = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_draw_modes();
        test_screen_edges();
        test_odd_sizes();
        test_streaming();
        test_backpressure();
        test_widest_row();
        test_random_sprites();

        wait_idle();
        repeat (10) @(posedge clk);
        mismatch_count += predicted_words.size();
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
